### rtl/circular_queue_with_remove_unit_assert.svh
// Assertion macros shared by the circular queue RTL.
`ifndef CIRCULAR_QUEUE_WITH_REMOVE_UNIT_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_REMOVE_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define CQR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CQR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/cqr_pkg.sv
// Types and constants of the circular queue with remove by value.
package cqr_pkg;

  localparam int CW      = 5;
  localparam int VALUE_W = 32;
  localparam int ADDR_W  = 3;

  localparam logic [CW-1:0] CAP_RESET    = 5'd16;
  localparam logic [0:0]    REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_NULL     = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT
  } state_e;

  typedef struct packed {
    op_e                opcode;
    logic [VALUE_W-1:0] entry_value;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] read_value;
    logic [CW-1:0]      fill_count;
  } out_t;

endpackage

### rtl/circular_queue_with_remove_unit.sv
// Circular queue of handle values with push, pop, peek and remove by value.
//
// Entries live in one synchronous memory with a single read and a single write port.
// A push and any operation that ends in full, empty or null status load their result
// directly from the idle state; a pop or peek loads it from the read state, after the
// registered memory read. A remove walks the queue through the read port one entry
// per cycle, first to find the match and then to move the later entries forward. The
// next transfer is accepted once the block is idle again and the output register is
// free (empty or not stalled). Writing the capacity register empties the queue at
// once; no clearing pass is needed since free slots are never read.
`include "circular_queue_with_remove_unit_assert.svh"

module circular_queue_with_remove_unit
  import cqr_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = (AW + 1 > CW) ? AW + 1 : CW;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] idx, logic [CW-1:0] cap);
    logic [IW-1:0] sum;
    sum = IW'(idx) + IW'(1);
    wrap_inc = (sum >= IW'(cap)) ? '0 : sum[AW-1:0];
  endfunction

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];
  logic [ENTRY_WIDTH-1:0] rd_data_q;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [ENTRY_WIDTH-1:0] wr_data;

  state_e                 state_q, state_d;
  logic [CW-1:0]          cap_q, cap_d;
  logic [CW-1:0]          cap_eff;
  logic [AW-1:0]          head_q, head_d;
  logic [AW-1:0]          tail_q, tail_d;
  logic [CW-1:0]          occ_q, occ_d;
  op_e                    op_q, op_d;
  logic [ENTRY_WIDTH-1:0] val_q, val_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   out_valid_q;
  out_t                   out_q;
  out_t                   out_res;
  logic                   out_load;
  logic                   out_free;
  logic                   in_xfer;
  logic                   cfg_we;
  logic [ENTRY_WIDTH-1:0] in_val;
  logic [AW-1:0]          tail_dec;
  logic [AW-1:0]          pos_inc;
  logic [AW-1:0]          pos_inc2;
  logic                   more;
  logic                   walk_active;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_CAPACITY);
  assign prdata  = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? 32'(cap_q) : '0;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_val     = ENTRY_WIDTH'(in_data_i.entry_value);

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign tail_dec    = (tail_q == '0) ? AW'(cap_eff - CW'(1)) : tail_q - AW'(1);
  assign pos_inc     = wrap_inc(pos_q, cap_eff);
  assign pos_inc2    = wrap_inc(pos_inc, cap_eff);
  assign more        = (cnt_q + CW'(1)) < occ_q;
  assign walk_active = (state_q == S_SCAN) || (state_q == S_SHIFT);

  always_comb begin
    state_d  = state_q;
    cap_d    = cap_q;
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    op_d     = op_q;
    val_d    = val_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    rd_en    = 1'b0;
    rd_addr  = head_q;
    wr_en    = 1'b0;
    wr_addr  = tail_q;
    wr_data  = in_val;
    out_load = 1'b0;
    out_res  = '{status: STAT_OK, read_value: '0, fill_count: '0};

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d  = in_data_i.opcode;
          val_d = in_val;
          case (in_data_i.opcode)
            OP_PUSH: begin
              out_load = 1'b1;
              if (occ_q >= cap_eff) begin
                out_res.status = STAT_FULL;
              end else begin
                wr_en  = 1'b1;
                tail_d = wrap_inc(tail_q, cap_eff);
                occ_d  = occ_q + CW'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (occ_q == '0) begin
                out_load       = 1'b1;
                out_res.status = STAT_EMPTY;
              end else begin
                rd_en   = 1'b1;
                state_d = S_READ;
              end
            end
            OP_REMOVE: begin
              if (in_val == '0) begin
                out_load       = 1'b1;
                out_res.status = STAT_NULL;
              end else if (occ_q == '0) begin
                out_load       = 1'b1;
                out_res.status = STAT_EMPTY;
              end else begin
                rd_en   = 1'b1;
                pos_d   = head_q;
                cnt_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              out_load       = 1'b1;
              out_res.status = STAT_NULL;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_res.read_value = VALUE_W'(rd_data_q);
          if (op_q == OP_POP) begin
            head_d = wrap_inc(head_q, cap_eff);
            occ_d  = occ_q - CW'(1);
          end
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (rd_data_q == val_q) begin
          if (more) begin
            rd_en   = 1'b1;
            rd_addr = pos_inc;
            cnt_d   = cnt_q + CW'(1);
            state_d = S_SHIFT;
          end else if (out_free) begin
            out_load = 1'b1;
            tail_d   = tail_dec;
            occ_d    = occ_q - CW'(1);
            state_d  = S_IDLE;
          end
        end else if (more) begin
          rd_en   = 1'b1;
          rd_addr = pos_inc;
          pos_d   = pos_inc;
          cnt_d   = cnt_q + CW'(1);
        end else if (out_free) begin
          out_load       = 1'b1;
          out_res.status = STAT_NOTFOUND;
          state_d        = S_IDLE;
        end
      end
      S_SHIFT: begin
        wr_addr = pos_q;
        wr_data = rd_data_q;
        if (more) begin
          wr_en   = 1'b1;
          pos_d   = pos_inc;
          rd_en   = 1'b1;
          rd_addr = pos_inc2;
          cnt_d   = cnt_q + CW'(1);
        end else if (out_free) begin
          wr_en    = 1'b1;
          out_load = 1'b1;
          tail_d   = tail_dec;
          occ_d    = occ_q - CW'(1);
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_res.fill_count = occ_d;

    if (cfg_we) begin
      cap_d  = pwdata[CW-1:0];
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    if (out_load) begin
      out_q <= out_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CQR_ASSERT_ALWAYS(a_occ_within_cap, occ_q <= cap_eff, "Occupancy exceeds capacity.")
  `CQR_ASSERT_ALWAYS(a_head_within_cap, IW'(head_q) < IW'(cap_eff), "Head index out of range.")
  `CQR_ASSERT_IMPLIES(a_empty_aligned, occ_q == '0, head_q == tail_q, "Empty queue misaligned.")
  `CQR_ASSERT_IMPLIES(a_walk_in_range, walk_active, cnt_q < occ_q, "Walk past the tail.")

endmodule

### tb/sv/circular_queue_with_remove_unit_tb.sv
// Self-checking testbench for the circular queue with push, pop, peek and remove by value.
module circular_queue_with_remove_unit_tb
  import cqr_pkg::*;
;

  localparam int QUEUE_DEPTH = 16;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_t               in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_t              out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  circular_queue_with_remove_unit #(
    .DEPTH(QUEUE_DEPTH),
    .ENTRY_WIDTH(VALUE_W)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Shadow copy of the queue contents and pointers.
  logic [VALUE_W-1:0] slot_mem [QUEUE_DEPTH] = '{default: '0};
  logic [CW-1:0]      cap_reg  = CAP_RESET;
  int unsigned        head_ptr = 0;
  int unsigned        tail_ptr = 0;
  int unsigned        held     = 0;

  out_t        expected_results [$];
  int unsigned fault_count   = 0;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned active_slots();
    if (cap_reg == 0) return 1;
    if (cap_reg > QUEUE_DEPTH) return QUEUE_DEPTH;
    return cap_reg;
  endfunction

  function automatic int unsigned next_slot(int unsigned i, int unsigned n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  function automatic void clear_queue_model();
    foreach (slot_mem[i]) slot_mem[i] = '0;
    head_ptr = 0;
    tail_ptr = 0;
    held     = 0;
  endfunction

  // Applies one operation to the shadow queue and returns the result it must produce.
  function automatic out_t queue_apply(in_t item);
    out_t        res;
    int unsigned n;
    int unsigned pos;
    int unsigned k;
    int unsigned nx;
    bit          hit;
    n = active_slots();
    if (head_ptr >= n) head_ptr = 0;
    if (tail_ptr >= n) tail_ptr = 0;
    if (held > n) held = n;
    res.status     = STAT_OK;
    res.read_value = '0;
    case (item.opcode)
      OP_PUSH: begin
        if (held >= n) begin
          res.status = STAT_FULL;
        end else begin
          slot_mem[tail_ptr] = item.entry_value;
          tail_ptr = next_slot(tail_ptr, n);
          held++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (held == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.read_value = slot_mem[head_ptr];
          if (item.opcode == OP_POP) begin
            slot_mem[head_ptr] = '0;
            head_ptr = next_slot(head_ptr, n);
            held--;
          end
        end
      end
      default: begin
        if (item.entry_value == '0) begin
          res.status = STAT_NULL;
        end else if (held == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          pos = head_ptr;
          hit = 1'b0;
          for (k = 0; k < held; k++) begin
            if (slot_mem[pos] == item.entry_value) begin
              hit = 1'b1;
              break;
            end
            pos = next_slot(pos, n);
          end
          if (!hit) begin
            res.status = STAT_NOTFOUND;
          end else begin
            for (k = k + 1; k < held; k++) begin
              nx = next_slot(pos, n);
              slot_mem[pos] = slot_mem[nx];
              pos = nx;
            end
            tail_ptr = (tail_ptr == 0) ? n - 1 : tail_ptr - 1;
            slot_mem[tail_ptr] = '0;
            held--;
          end
        end
      end
    endcase
    res.fill_count = CW'(held);
    return res;
  endfunction

  function automatic in_t make_op(op_e op, logic [VALUE_W-1:0] value);
    in_t item;
    item.opcode      = op;
    item.entry_value = value;
    return item;
  endfunction

  function automatic logic [VALUE_W-1:0] random_handle();
    case ($urandom_range(9))
      0:          return '1;
      1:          return '0;
      2, 3, 4, 5: return VALUE_W'($urandom_range(1, 6));
      default:    return VALUE_W'($urandom());
    endcase
  endfunction

  // Mostly well-formed traffic: removals usually name a value that is held.
  function automatic in_t random_op(int unsigned push_pct);
    in_t item;
    item.entry_value = random_handle();
    if ($urandom_range(99) < push_pct) begin
      item.opcode = OP_PUSH;
    end else begin
      case ($urandom_range(4))
        0, 1:    item.opcode = OP_POP;
        2:       item.opcode = OP_PEEK;
        default: begin
          item.opcode = OP_REMOVE;
          if (held > 0 && $urandom_range(3) != 0) begin
            item.entry_value =
              slot_mem[(head_ptr + $urandom_range(held - 1)) % active_slots()];
          end
        end
      endcase
    end
    return item;
  endfunction

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1:       begin in_idle_pct = 63; out_stall_pct = 0;  end
      2:       begin in_idle_pct = 0;  out_stall_pct = 63; end
      default: begin in_idle_pct = 31; out_stall_pct = 31; end
    endcase
  endtask

  task automatic send_op(input in_t item);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(queue_apply(item));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CW-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(REG_CAPACITY));
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_reg = value;
    clear_queue_model();
  endtask

  task automatic test_empty_queue();
    set_idling(0);
    send_op(make_op(OP_POP, 32'h0000_0000));
    send_op(make_op(OP_PEEK, 32'hFFFF_FFFF));
    send_op(make_op(OP_REMOVE, 32'h0000_0000));
    send_op(make_op(OP_REMOVE, 32'h0000_0007));
  endtask

  task automatic test_remove_cases();
    send_op(make_op(OP_PUSH, 32'hFFFF_FFFF));
    send_op(make_op(OP_PUSH, 32'h0000_0001));
    send_op(make_op(OP_PUSH, 32'h0000_0000));
    send_op(make_op(OP_PUSH, 32'h8000_0000));
    send_op(make_op(OP_PUSH, 32'h0000_0001));
    send_op(make_op(OP_PEEK, 32'h0000_0000));
    send_op(make_op(OP_REMOVE, 32'h0000_0009));
    send_op(make_op(OP_REMOVE, 32'h0000_0000));
    send_op(make_op(OP_REMOVE, 32'h0000_0001));
    repeat (4) send_op(make_op(OP_POP, 32'h0000_0000));
  endtask

  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_op(make_op(OP_PUSH, 32'h0000_0005));
    send_op(make_op(OP_PUSH, 32'h0000_0006));
    send_op(make_op(OP_REMOVE, 32'h0000_0005));
    write_capacity(5'd2);
    send_op(make_op(OP_PUSH, 32'h0000_00A0));
    send_op(make_op(OP_PUSH, 32'h0000_00B0));
    send_op(make_op(OP_POP, 32'h0000_0000));
    send_op(make_op(OP_PUSH, 32'h0000_00C0));
    send_op(make_op(OP_REMOVE, 32'h0000_00B0));
    send_op(make_op(OP_PEEK, 32'h0000_0000));
  endtask

  task automatic test_random_traffic();
    logic [CW-1:0] cap_plan [12] = '{5'd16, 5'd2, 5'd7, 5'd31, 5'd1, 5'd16,
                                     5'd0, 5'd12, 5'd17, 5'd3, 5'd9, 5'd16};
    int unsigned push_pct;
    push_pct = 40;
    for (int phase = 0; phase < 12; phase++) begin
      write_capacity(cap_plan[phase]);
      set_idling(phase % 4);
      for (int i = 0; i < 158; i++) begin
        if (i % 40 == 0) push_pct = $urandom_range(15, 65);
        send_op(random_op(push_pct));
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result transfer: status %0d value %h fill %0d",
                   out_data_o.status, out_data_o.read_value, out_data_o.fill_count);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o !== want) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: expected status %0d value %h fill %0d, got %0d %h %0d",
                     want.status, want.read_value, want.fill_count,
                     out_data_o.status, out_data_o.read_value, out_data_o.fill_count);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_remove_cases();
    test_capacity_limits();
    test_random_traffic();
    wait_drained();
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("circular_queue_with_remove_unit verification clean");
    end else begin
      $display("circular_queue_with_remove_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("circular_queue_with_remove_unit verification failed");
    $finish;
  end

endmodule
